[rtl/core/dpfb_pkg.sv]
// Shared types, constants and tables for the detection to frame box block.
`default_nettype none
package dpfb_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int CW            = 34;

    localparam logic [31:0] ANGLE_MASK   = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
    localparam logic [31:0] QUARTER_HALF = 32'h2000_0000;
    localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [64:0] HALF_Q30 = 65'sd536870912;

    localparam logic [31:0] ATAN_Q30 [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [1:0] {
        CFG_FRAME_MODE = 2'd0,
        CFG_MOUNT_X    = 2'd1,
        CFG_MOUNT_Y    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_BODY = 2'd0,
        MODE_MAP  = 2'd1
    } t_frame_mode;

    typedef struct packed {
        logic signed [31:0] range_dist;
        logic signed [15:0] bearing;
        logic signed [31:0] obj_height;
        logic signed [31:0] obj_width;
        logic signed [31:0] robot_pos_x;
        logic signed [31:0] robot_pos_y;
        logic signed [15:0] robot_yaw;
    } t_in;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        box_size_x;
        logic [30:0]        box_size_y;
        logic               frame_error;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           q;
    } t_cordic_st;

endpackage
`default_nettype wire

[rtl/core/dpfb_cordic.sv]
// Pipelined rotation CORDIC giving cosine and sine in Q2.30 of a binary angle.
`default_nettype none
module dpfb_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [15:0] i_angle,
    output logic signed [31:0]      o_cos,
    output logic signed [31:0]      o_sin
);
    dpfb_pkg::t_cordic_st r_st [0:dpfb_pkg::CORDIC_STAGES];
    dpfb_pkg::t_cordic_st n_st0;
    logic [31:0] full;
    logic [31:0] qsum;
    logic [31:0] zu;
    logic signed [dpfb_pkg::CW-1:0] cx;
    logic signed [dpfb_pkg::CW-1:0] sy;

    // split off the quadrant, leave z within an eighth turn of zero
    always_comb begin
        full     = {i_angle, 16'b0} & dpfb_pkg::ANGLE_MASK;
        qsum     = full + dpfb_pkg::QUARTER_HALF;
        n_st0.q  = qsum[31:30];
        zu       = full - {qsum[31:30], 30'b0};
        n_st0.x  = dpfb_pkg::INV_GAIN_Q30;
        n_st0.y  = '0;
        n_st0.z  = {{(dpfb_pkg::CW-32){zu[31]}}, zu};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    for (genvar i = 0; i < dpfb_pkg::CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [dpfb_pkg::CW-1:0] ATAN_I =
            {{(dpfb_pkg::CW-32){1'b0}}, dpfb_pkg::ATAN_Q30[i]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[i+1].q <= r_st[i].q;
                if (!r_st[i].z[dpfb_pkg::CW-1]) begin
                    r_st[i+1].x <= r_st[i].x - (r_st[i].y >>> i);
                    r_st[i+1].y <= r_st[i].y + (r_st[i].x >>> i);
                    r_st[i+1].z <= r_st[i].z - ATAN_I;
                end else begin
                    r_st[i+1].x <= r_st[i].x + (r_st[i].y >>> i);
                    r_st[i+1].y <= r_st[i].y - (r_st[i].x >>> i);
                    r_st[i+1].z <= r_st[i].z + ATAN_I;
                end
            end
        end
    end

    // apply the quadrant rotation exactly
    always_comb begin
        unique case (r_st[dpfb_pkg::CORDIC_STAGES].q)
            2'd0: begin
                cx = r_st[dpfb_pkg::CORDIC_STAGES].x;
                sy = r_st[dpfb_pkg::CORDIC_STAGES].y;
            end
            2'd1: begin
                cx = -r_st[dpfb_pkg::CORDIC_STAGES].y;
                sy = r_st[dpfb_pkg::CORDIC_STAGES].x;
            end
            2'd2: begin
                cx = -r_st[dpfb_pkg::CORDIC_STAGES].x;
                sy = -r_st[dpfb_pkg::CORDIC_STAGES].y;
            end
            default: begin
                cx = r_st[dpfb_pkg::CORDIC_STAGES].y;
                sy = -r_st[dpfb_pkg::CORDIC_STAGES].x;
            end
        endcase
        o_cos = cx[31:0];
        o_sin = sy[31:0];
    end
endmodule
`default_nettype wire

[rtl/core/detection_polar_to_frame_box_core.sv]
// Top level of the detection to frame box pipeline.
// Use:
//   Input channel (i_valid, o_stall, i_in): one detected object per request,
//   with the robot pose. An object with a negative height or width is dropped
//   and gives no result. Output channel (o_valid, i_stall, o_out): box centre
//   in body or map frame, box size and a frame error flag.
//   Config channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data):
//   frame mode, mount offset x and y. Always ready; write only when idle.
// Timing:
//   The pipeline has one angle preparation stage, one CORDIC stage per
//   iteration, then range multiply, body point add, rotation multiply and
//   output register. Throughput is one request per cycle unless the output
//   stalls; both angles run in parallel CORDICs.
// Reset: clears all valid bits and the config registers (body frame, zero
//   offsets). When the receiver stalls a held result, the whole pipeline
//   freezes and o_stall rises; nothing is lost or repeated.
`default_nettype none
module detection_polar_to_frame_box_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire dpfb_pkg::t_in   i_in,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output dpfb_pkg::t_out       o_out,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data
);
    localparam int CS = dpfb_pkg::CORDIC_STAGES;

    typedef struct packed {
        logic signed [31:0] range_dist;
        logic signed [31:0] obj_height;
        logic signed [31:0] obj_width;
        logic signed [31:0] robot_pos_x;
        logic signed [31:0] robot_pos_y;
    } t_side;

    logic               en;
    logic [1:0]         r_mode;
    logic signed [31:0] r_mox;
    logic signed [31:0] r_moy;

    t_side       r_sb [0:CS];
    logic [CS:0] r_sv;

    logic signed [31:0] cb, sb, cyaw, syaw;

    // range multiply stage
    logic               r_v1;
    logic signed [63:0] r_prc, r_prs;
    logic signed [31:0] r_hh1, r_cy1, r_sy1;
    t_side              r_sd1;

    // body point stage
    logic               r_v2;
    logic signed [31:0] r_bx, r_by, r_cy2, r_sy2;
    t_side              r_sd2;
    logic signed [63:0] rnd_c, rnd_s;

    // rotation multiply stage
    logic               r_v3;
    logic signed [31:0] r_bx3, r_by3;
    logic signed [63:0] r_pxc, r_pys, r_pxs, r_pyc;
    t_side              r_sd3;

    // output stage
    logic               r_ov;
    dpfb_pkg::t_out     r_out, n_out;
    logic signed [64:0] mx, my;

    // advance everything unless a held result is stalled
    assign en          = !(r_ov && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
            r_mox  <= '0;
            r_moy  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dpfb_pkg::CFG_FRAME_MODE: r_mode <= i_cfg_data[1:0];
                dpfb_pkg::CFG_MOUNT_X:    r_mox  <= i_cfg_data;
                dpfb_pkg::CFG_MOUNT_Y:    r_moy  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dpfb_cordic u_bearing (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_in.bearing),
        .o_cos   (cb),
        .o_sin   (sb)
    );

    dpfb_cordic u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_in.robot_yaw),
        .o_cos   (cyaw),
        .o_sin   (syaw)
    );

    // sideband line alongside the CORDICs; drop negative sizes at entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else if (en) begin
            r_sv <= {r_sv[CS-1:0],
                     i_valid && !i_in.obj_height[31] && !i_in.obj_width[31]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= '{i_in.range_dist, i_in.obj_height, i_in.obj_width,
                         i_in.robot_pos_x, i_in.robot_pos_y};
            for (int k = 1; k <= CS; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    always_comb begin
        rnd_c = r_prc + 64'sd536870912;
        rnd_s = r_prs + 64'sd536870912;
        mx = {r_pxc[63], r_pxc} - {r_pys[63], r_pys} + dpfb_pkg::HALF_Q30;
        my = {r_pxs[63], r_pxs} + {r_pyc[63], r_pyc} + dpfb_pkg::HALF_Q30;
        n_out.box_size_x  = r_sd3.obj_height[30:0];
        n_out.box_size_y  = r_sd3.obj_width[30:0];
        n_out.center_x    = '0;
        n_out.center_y    = '0;
        n_out.frame_error = 1'b0;
        case (r_mode)
            dpfb_pkg::MODE_BODY: begin
                n_out.center_x = r_bx3;
                n_out.center_y = r_by3;
            end
            dpfb_pkg::MODE_MAP: begin
                n_out.center_x = mx[61:30] + r_sd3.robot_pos_x;
                n_out.center_y = my[61:30] + r_sd3.robot_pos_y;
            end
            default: n_out.frame_error = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= r_sv[CS];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prc <= r_sb[CS].range_dist * cb;
            r_prs <= r_sb[CS].range_dist * sb;
            r_hh1 <= r_sb[CS].obj_height >>> 1;
            r_cy1 <= cyaw;
            r_sy1 <= syaw;
            r_sd1 <= r_sb[CS];

            r_bx  <= rnd_c[61:30] + r_hh1 + r_mox;
            r_by  <= rnd_s[61:30] + r_moy;
            r_cy2 <= r_cy1;
            r_sy2 <= r_sy1;
            r_sd2 <= r_sd1;

            r_pxc <= r_bx * r_cy2;
            r_pys <= r_by * r_sy2;
            r_pxs <= r_bx * r_sy2;
            r_pyc <= r_by * r_cy2;
            r_bx3 <= r_bx;
            r_by3 <= r_by;
            r_sd3 <= r_sd2;

            r_out <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_out   = r_out;

    // a flagged frame error always comes with a zero centre
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.frame_error |-> o_out.center_x == 0 && o_out.center_y == 0)
        else $error("frame error with nonzero centre");

    // a stalled held result must hold the input side off
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("pipeline advanced under output stall");

    // an entering object with a negative height gets no valid bit in the sideband line
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_in.obj_height[31] |=> !r_sv[0])
        else $error("negative size object not dropped");
endmodule
`default_nettype wire
